/* rtl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, status codes and the character map for the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // request opcodes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // result status codes
    localparam logic [2:0] ST_DATA       = 3'd0;
    localparam logic [2:0] ST_END_OK     = 3'd1;
    localparam logic [2:0] ST_BAD_CHAR   = 3'd2;
    localparam logic [2:0] ST_BAD_PAD    = 3'd3;
    localparam logic [2:0] ST_INCOMPLETE = 3'd4;
    localparam logic [2:0] ST_END_ERR    = 3'd5;

    // mapped character codes above the 64 alphabet sextets
    localparam logic [6:0] SEXTET_PAD = 7'd64;
    localparam logic [6:0] SEXTET_BAD = 7'd65;

    typedef struct packed {
        logic       op;
        logic [7:0] char_in;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] data_byte;
        logic       last;
    } t_out_item;

    // everything one request produces, handed to the output buffer
    typedef struct packed {
        logic [1:0] count;
        logic [2:0] status;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_grp_res;

    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        logic [7:0] d;
        d = {1'b0, SEXTET_BAD};
        case (c) inside
            [8'h41:8'h5A]: d = c - 8'h41;         // A-Z
            [8'h61:8'h7A]: d = c - 8'h47;         // a-z -> 26..51
            [8'h30:8'h39]: d = c + 8'h04;         // 0-9 -> 52..61
            8'h2B:         d = 8'd62;             // +
            8'h2F:         d = 8'd63;             // /
            8'h3D:         d = {1'b0, SEXTET_PAD}; // =
            default:       d = {1'b0, SEXTET_BAD};
        endcase
        return d[6:0];
    endfunction

endpackage

/* rtl/b64d_group.sv */
// ----------------------------------------------------------------------------
// b64d_group
// Group state and single-pass decode of one registered request.
// ----------------------------------------------------------------------------
module b64d_group (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  b64d_pkg::t_in_item  i_item,
    input  logic                i_advance,
    output b64d_pkg::t_grp_res  o_res
);

    logic [5:0] r_sx0, r_sx1, r_sx2;
    logic [5:0] n_sx0, n_sx1, n_sx2;
    logic [1:0] r_pos, n_pos;
    logic       r_pad, n_pad;
    logic       r_err, n_err;

    logic [6:0] sx;
    logic [5:0] sx_last;

    assign sx = b64d_pkg::char_to_sextet(i_item.char_in);

    always_comb begin
        n_sx0   = r_sx0;
        n_sx1   = r_sx1;
        n_sx2   = r_sx2;
        n_pos   = r_pos;
        n_pad   = r_pad;
        n_err   = r_err;
        sx_last = 6'd0;
        o_res   = '0;
        o_res.status = b64d_pkg::ST_DATA;

        if (i_item.op == b64d_pkg::OP_END) begin
            o_res.count = 2'd1;
            if (r_err) begin
                o_res.status = b64d_pkg::ST_END_ERR;
            end else if (r_pos != 2'd0) begin
                o_res.status = b64d_pkg::ST_INCOMPLETE;
            end else begin
                o_res.status = b64d_pkg::ST_END_OK;
            end
            n_pos = 2'd0;
            n_pad = 1'b0;
            n_err = 1'b0;
        end else if (r_err) begin
            // dropped until end of record
        end else if (sx == b64d_pkg::SEXTET_BAD) begin
            o_res.count  = 2'd1;
            o_res.status = b64d_pkg::ST_BAD_CHAR;
            n_err        = 1'b1;
        end else if ((r_pad && r_pos == 2'd0) ||
                     (sx == b64d_pkg::SEXTET_PAD && !r_pos[1])) begin
            o_res.count  = 2'd1;
            o_res.status = b64d_pkg::ST_BAD_PAD;
            n_err        = 1'b1;
        end else if (r_pos == 2'd2) begin
            if (sx == b64d_pkg::SEXTET_PAD) begin
                n_pad = 1'b1;
                n_sx2 = 6'd0;
            end else begin
                n_sx2 = sx[5:0];
            end
            n_pos = 2'd3;
        end else if (r_pos == 2'd0) begin
            n_sx0 = sx[5:0];
            n_pos = 2'd1;
        end else if (r_pos == 2'd1) begin
            n_sx1 = sx[5:0];
            n_pos = 2'd2;
        end else begin
            // fourth character closes the group
            if (r_pad && sx != b64d_pkg::SEXTET_PAD) begin
                o_res.count  = 2'd1;
                o_res.status = b64d_pkg::ST_BAD_PAD;
                n_err        = 1'b1;
            end else begin
                if (r_pad) begin
                    o_res.count = 2'd1;
                end else if (sx == b64d_pkg::SEXTET_PAD) begin
                    n_pad       = 1'b1;
                    o_res.count = 2'd2;
                end else begin
                    sx_last     = sx[5:0];
                    o_res.count = 2'd3;
                end
                o_res.b0 = {r_sx0, r_sx1[5:4]};
                o_res.b1 = {r_sx1[3:0], r_sx2[5:2]};
                o_res.b2 = {r_sx2[1:0], sx_last};
                n_pos    = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 2'd0;
            r_pad <= 1'b0;
            r_err <= 1'b0;
        end else if (i_advance) begin
            r_pos <= n_pos;
            r_pad <= n_pad;
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_sx0 <= n_sx0;
            r_sx1 <= n_sx1;
            r_sx2 <= n_sx2;
        end
    end

endmodule

/* rtl/b64d_out_buf.sv */
// ----------------------------------------------------------------------------
// b64d_out_buf
// Result register holding up to three results; drains one per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module b64d_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  b64d_pkg::t_grp_res  i_res,
    input  logic                i_ready,
    output logic                o_valid,
    output b64d_pkg::t_out_item o_item,
    output logic                o_empty_next
);

    logic [1:0] r_cnt, n_cnt;
    logic [2:0] r_status;
    logic [7:0] r_b0, r_b1, r_b2;
    logic       pop;

    assign o_valid      = (r_cnt != 2'd0);
    assign pop          = o_valid && i_ready;
    assign o_empty_next = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);

    assign o_item.status    = r_status;
    assign o_item.data_byte = r_b0;
    assign o_item.last      = (r_cnt == 2'd1);

    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_res.count;
        end else if (pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= i_res.status;
            r_b0     <= i_res.b0;
            r_b1     <= i_res.b1;
            r_b2     <= i_res.b2;
        end else if (pop) begin
            r_b0 <= r_b1;
            r_b1 <= r_b2;
        end
    end

endmodule

/* rtl/base64_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Base64 decoder: one character request in, decoded bytes and status out.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready, i_item): one request per ASCII character,
// or an end-of-record request that reports the record's outcome and clears
// the group state. Output channel (o_valid/i_ready, o_item): one result per
// decoded byte, error or end report; last marks the final result of a
// request.
// The group logic decodes the request held in the input register, and its
// first result is valid once the result register has loaded it; that load
// waits while earlier results still drain.
// Throughput: one request per cycle unless a request waits in the input
// register. A request that completes a group loads up to three bytes into
// the result register, which drains one per cycle while i_ready is high;
// a later group-closing or reporting request waits in the input register
// until that drain ends; filling characters pass even while results wait.
// Reset clears the input register, the result count and the group state.
// When the receiver stalls, results hold and the input register fills,
// after which o_ready drops.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  b64d_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output b64d_pkg::t_out_item o_item
);

    logic               r_in_valid;
    b64d_pkg::t_in_item r_in;
    b64d_pkg::t_grp_res res;
    logic               empty_next;
    logic               advance;

    assign advance = r_in_valid && (res.count == 2'd0 || empty_next);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_item;
        end
    end

    b64d_group u_group (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (r_in),
        .i_advance (advance),
        .o_res     (res)
    );

    b64d_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (advance && res.count != 2'd0),
        .i_res        (res),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_item       (o_item),
        .o_empty_next (empty_next)
    );

    // only data results come in multi-result bursts
    a_burst_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.last |-> o_item.status == b64d_pkg::ST_DATA)
        else $error("non-final result with non-data status");

    a_err_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status != b64d_pkg::ST_DATA |-> o_item.data_byte == 8'd0)
        else $error("status result carries a nonzero byte");

    // nothing can appear without a request in the input register
    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.last && i_ready && !r_in_valid |=> !o_valid)
        else $error("result appeared with no request pending");

endmodule
